// ----- sv/assert_macros.svh -----
// assert_macros.svh: assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock with an active-low reset that disables it.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent overlapping consequent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/taoct_pkg.sv -----
// taoct_pkg: types and fixed constants of the table atan2 octant pipeline.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package taoct_pkg;

  localparam int IN_W    = 32;  // coordinate width
  localparam int MAG_W   = 32;  // magnitude width, holds 2^31
  localparam int ANGLE_W = 13;  // result width

  // Sign and axis flags that travel with each word down the pipeline.
  typedef struct packed {
    logic yneg;
    logic xneg;
    logic yzero;
    logic xzero;
    logic low;    // |y| < |x|
  } ctrl_t;

endpackage

// ----- sv/taoct_front.sv -----
// taoct_front: magnitudes, octant compare and ratio numerator (three stages).
// Depends on taoct_pkg.
`timescale 1ns / 1ps

module taoct_front import taoct_pkg::*; #(
  parameter int ATAN_ENTRIES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [IN_W-1:0]               y_value_i,
  input  logic signed [IN_W-1:0]               x_value_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic [MAG_W+$clog2(ATAN_ENTRIES+1)-1:0] num_o,
  output logic [MAG_W-1:0]                     large_o,
  output ctrl_t                                ctrl_o
);

  localparam int IW = $clog2(ATAN_ENTRIES + 1);
  localparam int DW = MAG_W + IW;
  localparam logic [IW-1:0] N_C = IW'(ATAN_ENTRIES);

  logic             va_q, vb_q, vc_q;
  logic             rdy_a, rdy_b, rdy_c;
  logic [MAG_W-1:0] ym_d, xm_d, ym_q, xm_q;
  ctrl_t            ca_d, ca_q, cb_d, cb_q, cc_q;
  logic [MAG_W-1:0] small_d, large_d, small_q, large_q, large_c_q;
  logic [DW-1:0]    num_d, num_q;

  // A stage may load when it is empty or its word moves on.
  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  // Stage A: take magnitudes; the most negative input maps to 2^31 exactly.
  always_comb begin
    ym_d     = y_value_i[IN_W-1] ? (~y_value_i + 1'b1) : y_value_i;
    xm_d     = x_value_i[IN_W-1] ? (~x_value_i + 1'b1) : x_value_i;
    ca_d       = '0;
    ca_d.yneg  = y_value_i[IN_W-1];
    ca_d.xneg  = x_value_i[IN_W-1];
    ca_d.yzero = (y_value_i == '0);
    ca_d.xzero = (x_value_i == '0);
  end

  // Stage B: pick the smaller magnitude as the numerator.
  always_comb begin
    cb_d     = ca_q;
    cb_d.low = (ym_q < xm_q);
    small_d  = cb_d.low ? ym_q : xm_q;
    large_d  = cb_d.low ? xm_q : ym_q;
  end

  // Stage C: scale the numerator by the table size.
  assign num_d = DW'(small_q) * DW'(N_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      ym_q <= ym_d;
      xm_q <= xm_d;
      ca_q <= ca_d;
    end
    if (rdy_b && va_q) begin
      small_q <= small_d;
      large_q <= large_d;
      cb_q    <= cb_d;
    end
    if (rdy_c && vb_q) begin
      num_q     <= num_d;
      large_c_q <= large_q;
      cc_q      <= cb_q;
    end
  end

  assign valid_o = vc_q;
  assign num_o   = num_q;
  assign large_o = large_c_q;
  assign ctrl_o  = cc_q;

endmodule

// ----- sv/taoct_div.sv -----
// taoct_div: restoring divider, one quotient bit per pipeline stage.
// Depends on taoct_pkg.
`timescale 1ns / 1ps

module taoct_div import taoct_pkg::*; #(
  parameter int ATAN_ENTRIES = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic [MAG_W+$clog2(ATAN_ENTRIES+1)-1:0] num_i,
  input  logic [MAG_W-1:0]                        large_i,
  input  ctrl_t                                   ctrl_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [$clog2(ATAN_ENTRIES+1)-1:0]       quo_o,
  output ctrl_t                                   ctrl_o
);

  localparam int IW = $clog2(ATAN_ENTRIES + 1);
  localparam int DW = MAG_W + IW;

  logic [IW-1:0]    v_q;
  logic [IW:0]      rdy;
  logic [IW-1:0]    v_in;
  logic [DW-1:0]    rem_in [IW];
  logic [DW-1:0]    rem_q  [IW];
  logic [MAG_W-1:0] lg_in  [IW];
  logic [MAG_W-1:0] lg_q   [IW];
  logic [IW-1:0]    quo_in [IW];
  logic [IW-1:0]    quo_q  [IW];
  ctrl_t            ctl_in [IW];
  ctrl_t            ctl_q  [IW];

  assign rdy[IW]  = ready_i;
  assign ready_o  = rdy[0];

  for (genvar j = 0; j < IW; j++) begin : g_stage
    localparam int B = IW - 1 - j;  // quotient bit decided here
    logic [DW-1:0] sh;
    logic          ge;

    if (j == 0) begin : g_first
      assign v_in[j]   = valid_i;
      assign rem_in[j] = num_i;
      assign lg_in[j]  = large_i;
      assign quo_in[j] = '0;
      assign ctl_in[j] = ctrl_i;
    end else begin : g_next
      assign v_in[j]   = v_q[j-1];
      assign rem_in[j] = rem_q[j-1];
      assign lg_in[j]  = lg_q[j-1];
      assign quo_in[j] = quo_q[j-1];
      assign ctl_in[j] = ctl_q[j-1];
    end

    assign rdy[j] = !v_q[j] || rdy[j+1];
    assign sh     = DW'(lg_in[j]) << B;
    assign ge     = (rem_in[j] >= sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= v_in[j];
      end
    end

    // Subtract the shifted divisor when it fits and record the bit.
    always_ff @(posedge clk_i) begin
      if (rdy[j] && v_in[j]) begin
        rem_q[j] <= ge ? (rem_in[j] - sh) : rem_in[j];
        lg_q[j]  <= lg_in[j];
        quo_q[j] <= quo_in[j] | (IW'(ge) << B);
        ctl_q[j] <= ctl_in[j];
      end
    end
  end

  assign valid_o = v_q[IW-1];
  assign quo_o   = quo_q[IW-1];
  assign ctrl_o  = ctl_q[IW-1];

endmodule

// ----- sv/taoct_rom.sv -----
// taoct_rom: first-octant arctangent ROM with registered read.
// Depends on taoct_pkg; contents are built at elaboration by the series below.
`timescale 1ns / 1ps

module taoct_rom import taoct_pkg::*; #(
  parameter int MAX_DEGREE   = 4096,
  parameter int ATAN_ENTRIES = 1024
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [$clog2(ATAN_ENTRIES+1)-1:0]     idx_i,
  input  ctrl_t                                 ctrl_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [$clog2(MAX_DEGREE/8+1)-1:0]     tval_o,
  output ctrl_t                                 ctrl_o
);

  localparam int IW = $clog2(ATAN_ENTRIES + 1);
  localparam int TW = $clog2(MAX_DEGREE / 8 + 1);
  localparam logic [IW-1:0] N_C = IW'(ATAN_ENTRIES);

  typedef logic [TW-1:0] rom_t [ATAN_ENTRIES+1];

  // High half of a 64x64 product.
  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[127:64];
  endfunction

  // Long division by shift and subtract; returns {quotient, remainder}.
  function automatic logic [127:0] div_rem64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  // floor(num * 2^62 / den) for num < den < 2^31.
  function automatic logic [63:0] frac62(input logic [63:0] num, input logic [63:0] den);
    logic [127:0] qr;
    logic [63:0]  q1, r1, q2;
    qr = div_rem64(num << 31, den);
    q1 = qr[127:64];
    r1 = qr[63:0];
    qr = div_rem64(r1 << 31, den);
    q2 = qr[127:64];
    return (q1 << 31) | q2;
  endfunction

  // atan(i/n) in Q62 by the Euler series.
  function automatic logic [63:0] atan_q62(input logic [63:0] i, input logic [63:0] n);
    logic [63:0]  den, yq, g, term, sum, k;
    logic [127:0] qr;
    den  = n * n + i * i;
    yq   = frac62(i * i, den);
    g    = frac62(i * n, den);
    term = 64'd1 << 62;
    sum  = term;
    for (k = 64'd1; k < 64'd200 && term != 64'd0; k++) begin
      term = mul_hi(term, yq << 2);
      qr   = div_rem64(term, 64'd2 * k + 64'd1);
      term = term - qr[127:64];
      sum  = sum + term;
    end
    return mul_hi(sum, g << 2);
  endfunction

  function automatic rom_t build_rom();
    rom_t         r;
    logic [63:0]  eighth, a, v;
    logic [127:0] qr;
    eighth = atan_q62(64'(ATAN_ENTRIES), 64'(ATAN_ENTRIES)) >> 20;
    for (int i = 0; i <= ATAN_ENTRIES; i++) begin
      a    = atan_q62(64'(i), 64'(ATAN_ENTRIES)) >> 20;
      qr   = div_rem64(a * 64'(MAX_DEGREE), 64'd8 * eighth);
      v    = qr[127:64];
      r[i] = TW'(v);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic          v_q, rdy;
  logic [IW-1:0] idx_c;
  logic [TW-1:0] tval_q;
  ctrl_t         ctrl_q;

  assign rdy     = !v_q || ready_i;
  assign ready_o = rdy;
  // Clamp: only a zero divisor (both inputs zero) drives the quotient past the end.
  assign idx_c   = (idx_i > N_C) ? N_C : idx_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      tval_q <= ROM[idx_c];
      ctrl_q <= ctrl_i;
    end
  end

  assign valid_o = v_q;
  assign tval_o  = tval_q;
  assign ctrl_o  = ctrl_q;

endmodule

// ----- sv/taoct_back.sv -----
// taoct_back: reflect the table angle into its octant; output register.
// Depends on taoct_pkg.
`timescale 1ns / 1ps

module taoct_back import taoct_pkg::*; #(
  parameter int MAX_DEGREE = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [$clog2(MAX_DEGREE/8+1)-1:0] tval_i,
  input  ctrl_t                             ctrl_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [ANGLE_W-1:0]                angle_o
);

  localparam int CW = ($clog2(MAX_DEGREE) + 1 > ANGLE_W) ? $clog2(MAX_DEGREE) + 1 : ANGLE_W;
  localparam logic [CW-1:0] Q1 = CW'(MAX_DEGREE / 4);
  localparam logic [CW-1:0] Q2 = CW'(2 * (MAX_DEGREE / 4));
  localparam logic [CW-1:0] Q3 = CW'(3 * (MAX_DEGREE / 4));
  localparam logic [CW-1:0] Q4 = CW'(4 * (MAX_DEGREE / 4));

  logic               v_q, rdy;
  logic [CW-1:0]      t, ang_d;
  logic [ANGLE_W-1:0] angle_q;

  assign rdy     = !v_q || ready_i;
  assign ready_o = rdy;
  assign t       = CW'(tval_i);

  always_comb begin
    if (ctrl_i.yzero) begin
      ang_d = ctrl_i.xneg ? Q2 : '0;
    end else if (ctrl_i.xzero) begin
      ang_d = ctrl_i.yneg ? Q3 : Q1;
    end else if (!ctrl_i.xneg && !ctrl_i.yneg) begin
      ang_d = ctrl_i.low ? t : Q1 - t;
    end else if (!ctrl_i.xneg) begin
      ang_d = ctrl_i.low ? Q4 - t : Q3 + t;
    end else if (!ctrl_i.yneg) begin
      ang_d = ctrl_i.low ? Q2 - t : Q1 + t;
    end else begin
      ang_d = ctrl_i.low ? Q2 + t : Q3 - t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy) begin
      v_q <= valid_i;
    end
  end

  // Keep the low bits of the turn count.
  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      angle_q <= ang_d[ANGLE_W-1:0];
    end
  end

  assign valid_o = v_q;
  assign angle_o = angle_q;

endmodule

// ----- sv/table_atan2_octant.sv -----
// table_atan2_octant: top level of the pipelined table atan2 with octant reduction.
// Depends on taoct_pkg, taoct_front, taoct_div, taoct_rom and taoct_back.
//
//   channel  direction  handshake                  payload
//   in       to block   in_valid_i / in_ready_o    y_value_i, x_value_i (s32 each)
//   out      from block out_valid_o / out_ready_i  angle_o (u13)
//
// The stages are three front stages, one divider stage per quotient bit with
// IW = clog2(ATAN_ENTRIES + 1), the ROM read and the output register.
// Throughput is one word per cycle while the output is not stalled.
// Reset clears only the valid bits; the ROM is constant and needs no fill.
// Each stage loads when it is empty or its word moves on, so a stall at the
// output backs up stage by stage and bubbles in the pipe still take new words.
`timescale 1ns / 1ps

module table_atan2_octant import taoct_pkg::*; #(
  parameter int MAX_DEGREE   = 4096,
  parameter int ATAN_ENTRIES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [IN_W-1:0]    y_value_i,
  input  logic signed [IN_W-1:0]    x_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ANGLE_W-1:0]        angle_o
);

  localparam int IW = $clog2(ATAN_ENTRIES + 1);  // table index bits
  localparam int DW = MAG_W + IW;                // scaled numerator bits
  localparam int TW = $clog2(MAX_DEGREE / 8 + 1);// table entry bits

  // Front -> divider: numerator small*N, divisor larger magnitude.
  logic             fr_valid, fr_ready;
  logic [DW-1:0]    fr_num;
  logic [MAG_W-1:0] fr_large;
  ctrl_t            fr_ctrl;

  // Divider -> ROM: table index.
  logic             dv_valid, dv_ready;
  logic [IW-1:0]    dv_quo;
  ctrl_t            dv_ctrl;

  // ROM -> back end: first-octant angle.
  logic             rm_valid, rm_ready;
  logic [TW-1:0]    rm_tval;
  ctrl_t            rm_ctrl;

  taoct_front #(
    .ATAN_ENTRIES(ATAN_ENTRIES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .y_value_i (y_value_i),
    .x_value_i (x_value_i),
    .valid_o   (fr_valid),
    .ready_i   (fr_ready),
    .num_o     (fr_num),
    .large_o   (fr_large),
    .ctrl_o    (fr_ctrl)
  );

  taoct_div #(
    .ATAN_ENTRIES(ATAN_ENTRIES)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .num_i   (fr_num),
    .large_i (fr_large),
    .ctrl_i  (fr_ctrl),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .quo_o   (dv_quo),
    .ctrl_o  (dv_ctrl)
  );

  taoct_rom #(
    .MAX_DEGREE   (MAX_DEGREE),
    .ATAN_ENTRIES (ATAN_ENTRIES)
  ) u_rom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .ready_o (dv_ready),
    .idx_i   (dv_quo),
    .ctrl_i  (dv_ctrl),
    .valid_o (rm_valid),
    .ready_i (rm_ready),
    .tval_o  (rm_tval),
    .ctrl_o  (rm_ctrl)
  );

  // Hold the finished angle here until the consumer takes it.
  taoct_back #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rm_valid),
    .ready_o (rm_ready),
    .tval_i  (rm_tval),
    .ctrl_i  (rm_ctrl),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .angle_o (angle_o)
  );

endmodule

// ----- sv/taoct_checker.sv -----
// taoct_checker: port-level assertions for table_atan2_octant, bound to the top.
// Depends on taoct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module taoct_checker import taoct_pkg::*; #(
  parameter int MAX_DEGREE   = 4096,
  parameter int ATAN_ENTRIES = 1024
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic signed [IN_W-1:0] y_value_i,
  input logic signed [IN_W-1:0] x_value_i,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [ANGLE_W-1:0]     angle_o
);

  localparam int DEPTH = $clog2(ATAN_ENTRIES + 1) + 5;
  localparam int CNT_W = $clog2(DEPTH + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_q;
  logic             in_range;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_acc  = out_valid_o && out_ready_i;
  assign in_range = (MAX_DEGREE >= (1 << ANGLE_W)) || (32'(angle_o) <= 32'(MAX_DEGREE));

  // Count words inside the pipe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  `ASSERT_IMPL(a_no_invented, clk_i, rst_ni, out_valid_o, cnt_q != '0, "result with no word inside")
  `ASSERT_RST(a_depth, clk_i, rst_ni, 32'(cnt_q) <= 32'(DEPTH), "more words than pipeline stages")
  `ASSERT_IMPL(a_range, clk_i, rst_ni, out_valid_o, in_range, "angle beyond one full turn")
  `ASSERT_RST(a_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(angle_o)), "stalled result dropped or changed")

  // Inputs watched only through the handshake; keep payload ports referenced.
  logic unused_payload;
  assign unused_payload = ^{y_value_i, x_value_i};

endmodule

bind table_atan2_octant taoct_checker #(
  .MAX_DEGREE   (MAX_DEGREE),
  .ATAN_ENTRIES (ATAN_ENTRIES)
) u_checker (.*);
